// ===== hw/rtl/aes_pkg.sv =====
package aes_pkg;

	typedef logic [127:0] blk_t;

	localparam int unsigned NumRounds = 10;

	// Configuration register indexes.
	localparam logic CfgKeyHigh = 1'b0;
	localparam logic CfgKeyLow  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits in bits 127-8i down to 120-8i.
	function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
		get_byte = b[127 - 8 * i -: 8];
	endfunction

	// One key expansion step: round key r from round key r-1.
	function automatic blk_t next_key(input blk_t k, input logic [7:0] rcon);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

endpackage

// ===== hw/rtl/aes_round_cell.sv =====
module aes_round_cell #(
	parameter logic [7:0] RCON = 8'h01,
	parameter bit LAST = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  aes_pkg::blk_t st_in,
	input  aes_pkg::blk_t key_in,
	output logic          vld_q,
	output aes_pkg::blk_t st_q,
	output aes_pkg::blk_t key_q
);

	aes_pkg::blk_t sh;
	aes_pkg::blk_t mx;
	aes_pkg::blk_t rk;

	// SubBytes and ShiftRows together, then MixColumns per column.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[127 - 8 * (4 * c + r) -: 8] =
					aes_pkg::SBOX[aes_pkg::get_byte(st_in, 4 * ((c + r) % 4) + r)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sh[127 - 32 * c -: 8];
			a1 = sh[119 - 32 * c -: 8];
			a2 = sh[111 - 32 * c -: 8];
			a3 = sh[103 - 32 * c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mx[127 - 32 * c -: 8] = a0 ^ al ^ aes_pkg::xtime(a0 ^ a1);
			mx[119 - 32 * c -: 8] = a1 ^ al ^ aes_pkg::xtime(a1 ^ a2);
			mx[111 - 32 * c -: 8] = a2 ^ al ^ aes_pkg::xtime(a2 ^ a3);
			mx[103 - 32 * c -: 8] = a3 ^ al ^ aes_pkg::xtime(a3 ^ a0);
		end
		rk = aes_pkg::next_key(key_in, RCON);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q  <= (LAST ? sh : mx) ^ rk;
			key_q <= rk;
		end
	end

endmodule

// ===== hw/rtl/aes128_block_encrypt.sv =====
// AES-128 encryption pipeline: one round cell per round, ten in a row.
// An accepted input beat passes through the initial key addition register
// and then through one register per round cell to its output beat.
// Throughput: one block per cycle; the whole row advances whenever the
// output register is empty or being drained. Reset clears all valid bits
// and both key registers to zero.
module aes128_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	localparam logic [7:0] RCON [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;

	// The pipeline moves as one: the final cell is the output register, so the
	// row may step whenever that register is empty or its beat is taken.
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aes_pkg::CfgKeyHigh: key_high_q <= cfg_data;
				aes_pkg::CfgKeyLow:  key_low_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Stage zero: initial AddRoundKey. The cipher key travels alongside the
	// block so that every cell derives its own round key from its neighbour.
	logic          vld_s0;
	aes_pkg::blk_t st_s0;
	aes_pkg::blk_t key_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s0  <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			key_s0 <= {key_high_q, key_low_q};
		end
	end

	logic          vld [11];
	aes_pkg::blk_t st  [11];
	aes_pkg::blk_t key [11];

	assign vld[0] = vld_s0;
	assign st[0]  = st_s0;
	assign key[0] = key_s0;

	for (genvar r = 0; r < aes_pkg::NumRounds; r++) begin : g_round
		aes_round_cell #(
			.RCON (RCON[r]),
			.LAST (r == aes_pkg::NumRounds - 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_in (vld[r]),
			.st_in  (st[r]),
			.key_in (key[r]),
			.vld_q  (vld[r + 1]),
			.st_q   (st[r + 1]),
			.key_q  (key[r + 1])
		);
	end

	assign out_valid   = vld[10];
	assign cipher_high = st[10][127:64];
	assign cipher_low  = st[10][63:0];

	// A beat held back by the receiver keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("output beat changed while stalled");

	// The input side is stalled only while a finished beat waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without back-pressure");

	// An accepted beat reaches the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s0)
		else $error("accepted beat lost at entry");

endmodule

// ===== test/testbench.sv =====
`default_nettype none

// Block-level bench for the AES-128 encryption pipeline.
//
// Plaintext beats go in through the valid/stall input channel and ciphertext
// beats come back through the output channel. A predictor written here
// (its own S-box, key schedule and round functions) works out each ciphertext
// that is not typed in, as its plaintext beat is accepted. Every expected
// ciphertext is queued and compared, field by field, with the next output beat.
//
// The directed part is a short table. Its rows carry the published test
// vectors, with their ciphertexts typed in. It also covers the all-zero
// reset key, the all-ones key and the extreme plaintexts. The random part
// then runs in several key phases. Key writes happen only while the pipeline
// is empty and settled. Both channels idle at random, in stretches with no
// idling between them.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   PIPE_DEPTH   = 11;
	localparam int   RAND_BLOCKS  = 1530;
	localparam int   KEY_PHASES   = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	aes128_block_encrypt dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.plain_high(plain_high), .plain_low(plain_low),
		.out_valid(out_valid), .out_stall(out_stall),
		.cipher_high(cipher_high), .cipher_low(cipher_low)
	);

	always #4 clk = ~clk;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_t;

	typedef struct {
		logic        load_key;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] pt_hi;
		logic [63:0] pt_lo;
		logic        known;
		logic [63:0] ct_hi;
		logic [63:0] ct_lo;
	} vector_t;

	// The predictor's copy of the key registers. They reset to zero, as the block's do.
	logic [7:0]  sub_table [256];
	logic [63:0] cur_key_hi = '0;
	logic [63:0] cur_key_lo = '0;

	cipher_t ciphers_due [$];
	int      mismatches = 0;
	int      blocks_sent = 0;
	int      blocks_seen = 0;
	int      key_loads = 0;
	bit      quiet = 1'b0;
	bit      out_taken = 1'b0;
	int      out_hold = 0;

	// Multiply by x in GF(2^8), with the field polynomial reduction.
	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] x, input int s);
		return (x << s) | (x >> (8 - s));
	endfunction

	// Generate the S-box. The first register steps through the multiplicative
	// group (multiplication by 3) and the second through its inverses
	// (division by 3). The affine map is then applied to the inverse.
	task automatic build_sub_table();
		logic [7:0] p;
		logic [7:0] q;
		p = 8'h01;
		q = 8'h01;
		do begin
			p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
			q = q ^ (q << 1);
			q = q ^ (q << 2);
			q = q ^ (q << 4);
			if (q[7])
				q = q ^ 8'h09;
			sub_table[p] = q ^ rot8(q, 1) ^ rot8(q, 2) ^ rot8(q, 3) ^ rot8(q, 4) ^ 8'h63;
		end while (p != 8'h01);
		sub_table[0] = 8'h63;
	endtask

	// Full AES-128 encryption of one block. Byte i of the state is in column i/4, row i%4.
	function automatic cipher_t aes_encrypt(input logic [63:0] k_hi, input logic [63:0] k_lo,
			input logic [63:0] p_hi, input logic [63:0] p_lo);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] nx [16];
		logic [7:0] w [4];
		logic [7:0] f;
		logic [7:0] rc;
		logic [7:0] all;
		logic [7:0] a0, a1, a2, a3;
		cipher_t res;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			rk[i]     = k_hi[63 - 8 * i -: 8];
			rk[8 + i] = k_lo[63 - 8 * i -: 8];
			st[i]     = p_hi[63 - 8 * i -: 8];
			st[8 + i] = p_lo[63 - 8 * i -: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++)
				w[j] = rk[4 * (i - 1) + j];
			if (i % 4 == 0) begin
				// Rotate the word, substitute each byte, then add the round constant.
				f = w[0];
				w[0] = sub_table[w[1]] ^ rc;
				w[1] = sub_table[w[2]];
				w[2] = sub_table[w[3]];
				w[3] = sub_table[f];
				rc = gf_double(rc);
			end
			for (int j = 0; j < 4; j++)
				rk[4 * i + j] = rk[4 * (i - 4) + j] ^ w[j];
		end
		for (int i = 0; i < 16; i++)
			st[i] ^= rk[i];
		for (int r = 1; r <= 10; r++) begin
			// Byte substitution merged with the row shift.
			for (int c = 0; c < 4; c++)
				for (int row = 0; row < 4; row++)
					nx[4 * c + row] = sub_table[st[4 * ((c + row) % 4) + row]];
			st = nx;
			// The last round leaves out the column mixing.
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4 * c];
					a1 = st[4 * c + 1];
					a2 = st[4 * c + 2];
					a3 = st[4 * c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
					st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
					st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
					st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] ^= rk[16 * r + i];
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63 - 8 * i -: 8] = st[i];
			res.lo[63 - 8 * i -: 8] = st[8 + i];
		end
		return res;
	endfunction

	// A random wait for either side, or none at all in a quiet stretch.
	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// The output side. The decision to take a beat is made at the falling
	// edge, when the outputs are settled. The stall for the next beat is
	// then drawn at the rising edge.
	always @(negedge clk) begin
		cipher_t want;
		out_taken = arst_n && out_valid && !out_stall;
		if (out_taken) begin
			blocks_seen++;
			if (ciphers_due.size() == 0) begin
				$error("unexpected ciphertext beat %h_%h", cipher_high, cipher_low);
				mismatches++;
			end else begin
				want = ciphers_due.pop_front();
				if (cipher_high !== want.hi) begin
					$error("cipher_high: expected %h, got %h", want.hi, cipher_high);
					mismatches++;
				end
				if (cipher_low !== want.lo) begin
					$error("cipher_low: expected %h, got %h", want.lo, cipher_low);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (out_taken)
			out_hold = draw_wait();
		else if (out_hold > 0)
			out_hold--;
		out_stall <= (out_hold > 0);
	end

	// Key writes happen only once the pipeline has drained. There is also a
	// settling pause first, so that no beat is still in flight.
	task automatic load_key(input logic [63:0] k_hi, input logic [63:0] k_lo);
		in_valid <= 1'b0;
		wait (ciphers_due.size() == 0);
		@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= aes_pkg::CfgKeyHigh;
		cfg_data  <= k_hi;
		@(posedge clk);
		cfg_index <= aes_pkg::CfgKeyLow;
		cfg_data  <= k_lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_key_hi = k_hi;
		cur_key_lo = k_lo;
		key_loads++;
	endtask

	// Present one plaintext beat and hold it until it is taken. The valid stays
	// high across back-to-back beats.
	task automatic send_block(input logic [63:0] p_hi, input logic [63:0] p_lo,
			input logic known, input logic [63:0] c_hi, input logic [63:0] c_lo);
		int gap;
		cipher_t due;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		plain_high <= p_hi;
		plain_low  <= p_lo;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (known) begin
			due.hi = c_hi;
			due.lo = c_lo;
		end else begin
			due = aes_encrypt(cur_key_hi, cur_key_lo, p_hi, p_lo);
		end
		ciphers_due.push_back(due);
		blocks_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly random halves, with the odd all-zero or all-ones half.
	function automatic logic [63:0] rand_half();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return rand64();
		endcase
	endfunction

	vector_t directed [] = '{
		// The reset key is all zero; the known ciphertext of a zero block under it.
		'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0,
			1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
		'{1'b0, 64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0},
		'{1'b0, 64'h0, 64'h0, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0},
		// The standard's worked example in its appendix on the cipher.
		'{1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h0011223344556677, 64'h8899aabbccddeeff,
			1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
		'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
		'{1'b0, 64'h0, 64'h0, '1, 64'h0, 1'b0, 64'h0, 64'h0},
		// The key-expansion example from the standard.
		'{1'b1, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
			64'h3243f6a8885a308d, 64'h313198a2e0370734,
			1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32},
		// The all-ones key, with the extreme and alternating plaintexts.
		'{1'b1, '1, '1, '1, '1, 1'b0, 64'h0, 64'h0},
		'{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
		'{1'b0, 64'h0, 64'h0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
			1'b0, 64'h0, 64'h0},
		// Only one half of the key non-zero, each way round.
		'{1'b1, 64'h0, '1, 64'h0123456789abcdef, 64'hfedcba9876543210,
			1'b0, 64'h0, 64'h0},
		'{1'b1, '1, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210,
			1'b0, 64'h0, 64'h0}
	};

	initial begin
		build_sub_table();
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= aes_pkg::CfgKeyHigh;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		plain_high <= '0;
		plain_low  <= '0;
		out_stall  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the first rows run on the reset key.
		foreach (directed[i]) begin
			if (directed[i].load_key)
				load_key(directed[i].key_hi, directed[i].key_lo);
			send_block(directed[i].pt_hi, directed[i].pt_lo, directed[i].known,
				directed[i].ct_hi, directed[i].ct_lo);
		end

		// Random phases; each phase after the first loads a new key. The first
		// keeps the last key of the directed table and the last goes back to the all-zero key.
		for (int ph = 0; ph < KEY_PHASES; ph++) begin
			if (ph == KEY_PHASES - 1)
				load_key('0, '0);
			else if (ph > 0)
				load_key(rand64(), rand64());
			for (int n = 0; n < RAND_BLOCKS / KEY_PHASES; n++) begin
				if (n % 64 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				// Once per phase the sender holds off until the pipeline has drained.
				if (n == 100) begin
					in_valid <= 1'b0;
					wait (ciphers_due.size() == 0);
					@(posedge clk);
				end
				send_block(rand_half(), rand_half(), 1'b0, '0, '0);
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		wait (ciphers_due.size() == 0);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		$display("Encrypted %0d blocks under %0d key loads, %0d ciphertext beats checked.",
			blocks_sent, key_loads, blocks_seen);
		if (mismatches == 0 && ciphers_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/aes_pkg.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes128_block_encrypt.sv
test/testbench.sv
